>>> rtl/core/servo_ramp_setpoint_generator_unit_assert.svh
// assertion macros for the servo ramp checker file
`ifndef SERVO_RAMP_SETPOINT_GENERATOR_UNIT_ASSERT_SVH
`define SERVO_RAMP_SETPOINT_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SRSG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SRSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/srsg_pkg.sv
// types, constants and tables of the servo ramp setpoint generator
package srsg_pkg;

    // request and result items
    typedef struct packed {
        logic        cmd;
        logic [11:0] speed_code;
    } t_in_item;

    typedef struct packed {
        logic [11:0] pulse_us;
        logic [31:0] elapsed_ms;
        logic [31:0] duration_ms;
        logic        is_echo;
    } t_out_item;

    // configuration register indexes
    localparam logic [7:0] CFG_PULSE_MIN   = 8'd0;
    localparam logic [7:0] CFG_PULSE_MAX   = 8'd1;
    localparam logic [7:0] CFG_START_DELAY = 8'd2;
    localparam logic [7:0] CFG_CLEAR_DELAY = 8'd3;

    // register reset values
    localparam logic [11:0] PULSE_MIN_RST   = 12'd950;
    localparam logic [11:0] PULSE_MAX_RST   = 12'd1800;
    localparam logic [15:0] START_DELAY_RST = 16'd5000;
    localparam logic [15:0] CLEAR_DELAY_RST = 16'd10000;

    // speed code layout
    localparam logic [3:0] EXP_BIAS = 4'h8;

    // divider widths: dividend covers offset times span, divisor covers a duration
    localparam int DIV_W = 44;
    localparam int DEN_W = 32;
    localparam int CNT_W = $clog2(DIV_W + 1);

    localparam logic [31:0] DUR_MAX = 32'hFFFF_FFFF;

    // multiplier operand widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 27;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIVS,
        S_DIVW,
        S_OUT
    } t_state;

    // powers of ten up to 10^8
    function automatic logic [MUL_B_W-1:0] pow10(input logic [3:0] k);
        logic [MUL_B_W-1:0] r;
        case (k)
            4'd0:    r = 27'd1;
            4'd1:    r = 27'd10;
            4'd2:    r = 27'd100;
            4'd3:    r = 27'd1000;
            4'd4:    r = 27'd10000;
            4'd5:    r = 27'd100000;
            4'd6:    r = 27'd1000000;
            4'd7:    r = 27'd10000000;
            4'd8:    r = 27'd100000000;
            default: r = 27'd1;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/servo_ramp_setpoint_generator_unit.sv
// top level of the servo ramp setpoint generator
//
//  channel   direction  handshake                    payload
//  request   in         i_valid / o_ready            i_data     (t_in_item)
//  result    out        o_valid / i_ready            o_data     (t_out_item)
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// a tick that needs no ramp point, or a zero-mantissa command, passes S_EVAL and
// S_OUT from accept back to ready; any other command, or a tick inside the ramp
// window, also passes S_MUL, S_DIVS and the 44-step bit-serial divider; both share
// one request at a time; the output register lets the next request in while
// a result waits, and a full output register holds the sequencer in S_OUT
// synchronous active-low reset, no clearing pass; config is always ready
module servo_ramp_setpoint_generator_unit
    import srsg_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // compare width: holds the counter and duration plus a delay, with room to spare
    localparam int CMP_W = ((TIME_BITS > 33) ? TIME_BITS : 33) + 1;
    localparam int PROD_W = MUL_A_W + MUL_B_W;

    t_state r_state, n_state;

    // configuration registers
    logic [11:0] r_pmin;
    logic [11:0] r_pmax;
    logic [15:0] r_sdly;
    logic [15:0] r_cdly;

    // generator state
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [31:0]          r_dur, n_dur;
    logic [11:0]          r_pulse, n_pulse;

    // latched request
    logic        r_cmd, n_cmd;
    logic [11:0] r_code, n_code;

    // divider operands
    logic [DIV_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_den, n_den;

    // output register
    t_out_item r_out, n_out;
    logic      r_out_valid, n_out_valid;

    logic [11:0]        span;
    logic [7:0]         mant;
    logic [3:0]         expf;
    logic               exp_small;
    logic [3:0]         pow_idx;
    logic [CMP_W-1:0]   t_ext;
    logic [CMP_W-1:0]   win_end;
    logic [CMP_W-1:0]   clr_pt;
    logic [CMP_W-1:0]   t_off;
    logic               in_win;
    logic               past_clr;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic               accept;
    logic               out_load;

    t_div_req div_req;
    t_div_rsp div_rsp;

    assign accept   = i_valid && o_ready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // span clamps at zero for inverted limits
    assign span = (r_pmax > r_pmin) ? (r_pmax - r_pmin) : 12'd0;

    assign mant      = r_code[11:4];
    assign expf      = r_code[3:0];
    assign exp_small = expf <= EXP_BIAS;
    assign pow_idx   = exp_small ? (EXP_BIAS - expf) : (expf - EXP_BIAS);

    // ramp window and clear point, full width so nothing wraps
    assign t_ext    = CMP_W'(r_time);
    assign win_end  = CMP_W'(r_dur) + CMP_W'(r_sdly);
    assign clr_pt   = CMP_W'(r_dur) + CMP_W'(r_cdly);
    assign t_off    = t_ext - CMP_W'(r_sdly);
    assign in_win   = (t_ext > CMP_W'(r_sdly)) && (t_ext < win_end);
    assign past_clr = t_ext > clr_pt;

    // the one multiplier: offset*span for a ramp point, span*10^k or m*10^k
    // for a command
    always_comb begin
        if (!r_cmd) begin
            mul_a = t_off[31:0];
            mul_b = MUL_B_W'(span);
        end else if (exp_small) begin
            mul_a = MUL_A_W'(span);
            mul_b = pow10(pow_idx);
        end else begin
            mul_a = MUL_A_W'(mant);
            mul_b = pow10(pow_idx);
        end
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign div_req.start    = (r_state == S_DIVS);
    assign div_req.dividend = r_num;
    assign div_req.divisor  = r_den;

    srsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_cmd) begin
                    n_state = (mant == 8'd0) ? S_OUT : S_MUL;
                end else if (r_dur != 32'd0 && in_win) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MUL:  n_state = S_DIVS;
            S_DIVS: n_state = S_DIVW;
            S_DIVW: begin
                if (div_rsp.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_time      = r_time;
        n_dur       = r_dur;
        n_pulse     = r_pulse;
        n_cmd       = r_cmd;
        n_code      = r_code;
        n_num       = r_num;
        n_den       = r_den;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd  = i_data.cmd;
                    n_code = i_data.speed_code;
                    // command restarts the counter, a tick advances it
                    n_time = i_data.cmd ? '0 : r_time + TIME_BITS'(1);
                end
            end
            S_EVAL: begin
                if (r_cmd) begin
                    // zero mantissa means no ramp
                    if (mant == 8'd0) n_dur = 32'd0;
                end else if (r_dur == 32'd0) begin
                    n_pulse = r_pmin;
                end else if (!in_win && past_clr) begin
                    n_dur = 32'd0;
                end
            end
            S_MUL: begin
                if (!r_cmd) begin
                    n_num = prod[DIV_W-1:0];
                    n_den = r_dur;
                end else if (exp_small) begin
                    n_num = prod[DIV_W-1:0];
                    n_den = DEN_W'(mant);
                end else begin
                    n_num = DIV_W'(span);
                    n_den = prod[DEN_W-1:0];
                end
            end
            S_DIVS: begin
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    if (r_cmd) begin
                        // saturate the duration at 32 bits
                        n_dur = (div_rsp.quotient[DIV_W-1:32] != '0) ?
                                DUR_MAX : div_rsp.quotient[31:0];
                    end else begin
                        n_pulse = div_rsp.quotient[11:0] + r_pmin;
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_out.pulse_us    = r_pulse;
                    n_out.elapsed_ms  = t_ext[31:0];
                    n_out.duration_ms = r_dur;
                    n_out.is_echo     = r_cmd;
                    n_out_valid       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_time      <= '0;
            r_dur       <= 32'd0;
            r_pulse     <= PULSE_MIN_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_time      <= n_time;
            r_dur       <= n_dur;
            r_pulse     <= n_pulse;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_code <= n_code;
        r_num  <= n_num;
        r_den  <= n_den;
        r_out  <= n_out;
    end

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pmin <= PULSE_MIN_RST;
            r_pmax <= PULSE_MAX_RST;
            r_sdly <= START_DELAY_RST;
            r_cdly <= CLEAR_DELAY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PULSE_MIN:   r_pmin <= i_cfg_data[11:0];
                CFG_PULSE_MAX:   r_pmax <= i_cfg_data[11:0];
                CFG_START_DELAY: r_sdly <= i_cfg_data;
                CFG_CLEAR_DELAY: r_cdly <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

>>> rtl/core/srsg_div.sv
// restoring bit-serial divider, one quotient bit per cycle
module srsg_div
    import srsg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    // partial remainder stays below the divisor, so one spare bit is enough
    assign rem_sh  = {r_rem, r_quo[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign fits    = rem_sh >= {1'b0, r_den};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (r_busy) begin
            n_quo = {r_quo[DIV_W-2:0], fits};
            n_rem = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_den  = i_req.divisor;
            n_cnt  = CNT_W'(DIV_W);
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> rtl/core/srsg_checker.sv
// port-level checker for the servo ramp generator, bound to the top level
`include "servo_ramp_setpoint_generator_unit_assert.svh"

module srsg_checker
    import srsg_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input t_out_item   o_data
);

    // a stalled result holds
    `SRSG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data), "result changed while stalled")

    // a command echo always reports a restarted counter
    `SRSG_ASSERT_IMPL(a_echo_zero, i_clk, i_rst_n, o_valid && o_data.is_echo, o_data.elapsed_ms == 32'd0, "echo with nonzero elapsed time")

    // the sequencer is busy right after taking a request
    `SRSG_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "request taken while still working")

    // a result never shows up in the cycle right after its request
    `SRSG_ASSERT_IMPL(a_no_early, i_clk, i_rst_n, $rose(o_valid), !$past(i_valid && o_ready), "result appeared too early")

endmodule

bind servo_ramp_setpoint_generator_unit srsg_checker u_srsg_checker (.*);

>>> tb/servo_ramp_setpoint_generator_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the servo ramp setpoint generator
module servo_ramp_setpoint_generator_unit_tb;
    import srsg_pkg::*;

    // register index that maps to nothing, writes to it must be dropped
    localparam logic [7:0] CFG_UNMAPPED = 8'd9;
    // cycles with no handshake on any channel before the run is declared hung
    localparam int QUIET_LIMIT = 4000;
    // settle time after the last result
    localparam int DRAIN_CYCLES = 100;
    // longest tick run that follows one speed command
    localparam int MAX_SEQ_TICKS = 100;
    // speed codes are searched for a ramp no longer than this
    localparam int SHORT_RAMP_MS = 60;

    // predicts each setpoint and compares it with what the block returns
    class ramp_scoreboard;
        logic [11:0] pulse_min;
        logic [11:0] pulse_max;
        logic [15:0] start_delay;
        logic [15:0] clear_delay;
        logic [31:0] elapsed;
        logic [31:0] duration;
        logic [11:0] pulse;
        t_out_item   pending_setpoints[$];
        int          mismatches;
        int          compared;
        int          requests;
        int          commands;
        int          ramp_ticks;

        function new();
            pulse_min   = PULSE_MIN_RST;
            pulse_max   = PULSE_MAX_RST;
            start_delay = START_DELAY_RST;
            clear_delay = CLEAR_DELAY_RST;
            elapsed     = '0;
            duration    = '0;
            pulse       = PULSE_MIN_RST;
            mismatches  = 0;
            compared    = 0;
            requests    = 0;
            commands    = 0;
            ramp_ticks  = 0;
        endfunction

        function void write_register(logic [7:0] index, logic [15:0] data);
            case (index)
                CFG_PULSE_MIN:   pulse_min   = data[11:0];
                CFG_PULSE_MAX:   pulse_max   = data[11:0];
                CFG_START_DELAY: start_delay = data;
                CFG_CLEAR_DELAY: clear_delay = data;
                default: ;
            endcase
        endfunction

        // span clamps at zero when the limits are inverted
        function logic [63:0] span();
            return (pulse_max > pulse_min) ? 64'(pulse_max - pulse_min) : 64'd0;
        endfunction

        function logic [63:0] decade(int unsigned n);
            logic [63:0] r;
            r = 64'd1;
            repeat (n) r = r * 64'd10;
            return r;
        endfunction

        // exact floor(span / (m * 10^(x-8))), saturating at 32 bits
        function logic [31:0] ramp_duration_for(logic [11:0] code);
            logic [63:0] m;
            logic [63:0] q;
            logic [3:0]  x;
            m = 64'(code[11:4]);
            x = code[3:0];
            if (m == 0)
                return 32'd0;
            if (x <= EXP_BIAS)
                q = span() * decade(EXP_BIAS - x) / m;
            else
                q = span() / (m * decade(x - EXP_BIAS));
            return (q > 64'(DUR_MAX)) ? DUR_MAX : q[31:0];
        endfunction

        function void note_request(t_in_item req);
            t_out_item   setpoint;
            logic [63:0] t;
            logic [63:0] d;
            requests++;
            if (req.cmd) begin
                commands++;
                duration = ramp_duration_for(req.speed_code);
                elapsed  = '0;
            end else begin
                elapsed = elapsed + 32'd1;
                if (duration == 0) begin
                    pulse = pulse_min;
                end else begin
                    t = 64'(elapsed);
                    d = 64'(duration);
                    if (t > 64'(start_delay) && t < d + 64'(start_delay)) begin
                        pulse = 12'(((t - 64'(start_delay)) * span()) / d + 64'(pulse_min));
                        ramp_ticks++;
                    end else if (t > d + 64'(clear_delay)) begin
                        duration = '0;
                    end
                end
            end
            setpoint.pulse_us    = pulse;
            setpoint.elapsed_ms  = elapsed;
            setpoint.duration_ms = duration;
            setpoint.is_echo     = req.cmd;
            pending_setpoints.push_back(setpoint);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_setpoints.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                mismatches++;
                return;
            end
            want = pending_setpoints.pop_front();
            compared++;
            if (got.pulse_us !== want.pulse_us) begin
                $error("pulse_us: expected %0d, got %0d", want.pulse_us, got.pulse_us);
                mismatches++;
            end
            if (got.elapsed_ms !== want.elapsed_ms) begin
                $error("elapsed_ms: expected %0d, got %0d", want.elapsed_ms, got.elapsed_ms);
                mismatches++;
            end
            if (got.duration_ms !== want.duration_ms) begin
                $error("duration_ms: expected %0d, got %0d", want.duration_ms,
                       got.duration_ms);
                mismatches++;
            end
            if (got.is_echo !== want.is_echo) begin
                $error("is_echo: expected %0d, got %0d", want.is_echo, got.is_echo);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    t_in_item    i_data      = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    t_out_item   o_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    ramp_scoreboard setpoint_sb = new();

    // idle percentages of the request sender and the result receiver
    int sender_idle_pct   = 12;
    int receiver_idle_pct = 71;
    int settings_used     = 0;
    int quiet_cycles      = 0;

    servo_ramp_setpoint_generator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // receiver stalls at random, re-decided every cycle
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // every handshake is observed at the rising edge, before the block updates;
    // a result is checked before the request accepted at the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                setpoint_sb.check_result(o_data);
            if (i_valid && o_ready)
                setpoint_sb.note_request(i_data);
            if (i_cfg_valid && o_cfg_ready)
                setpoint_sb.write_register(i_cfg_index, i_cfg_data);
        end
    end

    // hang detector: any handshake on any channel counts as progress
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // entered at a falling edge and left at a falling edge with valid still high,
    // so the next call either replaces the request or drops valid, never both
    task automatic send_request(input logic cmd, input logic [11:0] code);
        t_in_item req;
        req.cmd        = cmd;
        req.speed_code = code;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(0, 99) < sender_idle_pct)
                @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop sending and wait until every predicted setpoint has come back
    task automatic settle_block();
        i_valid <= 1'b0;
        while (setpoint_sb.pending_setpoints.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // leaves the config valid high, the caller drops it after the last write
    task automatic write_setting(input logic [7:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // pulse limits carry random junk in the unused upper bits of the write data
    task automatic apply_settings(input logic [11:0] lo, input logic [11:0] hi,
                                  input logic [15:0] start_ms, input logic [15:0] clear_ms);
        settle_block();
        if (settings_used == 0 || $urandom_range(0, 3) == 0)
            write_setting(CFG_UNMAPPED, 16'($urandom));
        write_setting(CFG_PULSE_MIN, {4'($urandom), lo});
        write_setting(CFG_PULSE_MAX, {4'($urandom), hi});
        write_setting(CFG_START_DELAY, start_ms);
        write_setting(CFG_CLEAR_DELAY, clear_ms);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // narrow spans and short delays so ramps run to the clear point quickly;
    // now and then the limits are inverted or equal
    task automatic random_settings();
        logic [11:0] lo;
        logic [11:0] hi;
        lo = 12'($urandom);
        if ($urandom_range(0, 9) == 0)
            hi = 12'($urandom_range(0, lo));
        else
            hi = (lo > 12'd4015) ? 12'd4095 : lo + 12'($urandom_range(0, 80));
        apply_settings(lo, hi, 16'($urandom_range(0, 12)), 16'($urandom_range(0, 20)));
    endtask

    // mostly a speed command followed by enough ticks to pass the clear point,
    // the rest short runs of random commands and ticks
    task automatic run_random(input int budget);
        int          sent;
        int          burst;
        int          tries;
        logic [11:0] code;
        logic [63:0] window;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) < 8) begin
                tries = 0;
                do begin
                    code = {8'($urandom), ($urandom_range(0, 3) == 0) ?
                            4'($urandom) : 4'($urandom_range(6, 15))};
                    tries++;
                end while (setpoint_sb.ramp_duration_for(code) > SHORT_RAMP_MS && tries < 20);
                window = 64'(setpoint_sb.start_delay) + 64'(setpoint_sb.clear_delay)
                       + 64'(setpoint_sb.ramp_duration_for(code)) + 64'($urandom_range(1, 3));
                burst = (window > MAX_SEQ_TICKS) ? MAX_SEQ_TICKS : int'(window);
                if (burst > budget - sent)
                    burst = budget - sent;
                send_request(1'b1, code);
                repeat (burst) send_request(1'b0, 12'($urandom));
                sent += burst + 1;
            end else begin
                burst = $urandom_range(1, 6);
                repeat (burst) send_request(1'($urandom), 12'($urandom));
                sent += burst;
            end
        end
    endtask

    initial begin
        int phase;
        int step;

        // synchronous reset held low, then released at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset limits (950..1800, delays 5000 / 10000)
        send_request(1'b0, 12'hFFF);  // tick while idle snaps to the minimum
        send_request(1'b1, 12'h000);  // zero mantissa leaves the generator idle
        send_request(1'b1, 12'hFF0);  // largest mantissa, smallest exponent
        send_request(1'b1, 12'h010);  // quotient above 32 bits saturates
        send_request(1'b1, 12'h01F);  // largest exponent floors to zero
        send_request(1'b1, 12'h0A8);  // 85 ms ramp behind a long start delay
        send_request(1'b0, 12'h000);  // pulse holds before the ramp starts

        // short window: 60 us span over 10 ms, start 2 ms, clear 3 ms past the duration,
        // ticks walk through hold, ramp, hold past the window, clear and idle
        apply_settings(12'd100, 12'd160, 16'd2, 16'd3);
        send_request(1'b1, 12'h068);
        repeat (15) send_request(1'b0, 12'($urandom));

        // limits inverted while a ramp is active: the ramp holds the minimum
        send_request(1'b1, 12'h068);
        apply_settings(12'd3000, 12'd200, 16'd2, 16'd3);
        repeat (3) send_request(1'b0, 12'($urandom));

        // random part: three idling patterns, five register settings in each
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 12;
                    receiver_idle_pct = 71;
                end
                1: begin
                    sender_idle_pct   = 71;
                    receiver_idle_pct = 12;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (step = 0; step < 5; step++) begin
                if (step == 0) begin
                    // all registers at their low extreme
                    apply_settings(12'd0, 12'd0, 16'd0, 16'd0);
                    run_random(40);
                end else if (step == 1 && phase == 0) begin
                    // full span and the longest delays
                    apply_settings(12'd4095 - 12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF);
                    run_random(20);
                end else begin
                    random_settings();
                    run_random(70);
                end
            end
        end

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (setpoint_sb.pending_setpoints.size() != 0) begin
            $error("%0d setpoints never returned", setpoint_sb.pending_setpoints.size());
            setpoint_sb.mismatches++;
        end

        $display("ran %0d requests (%0d speed commands, %0d ticks on a ramp) over %0d settings",
                 setpoint_sb.requests, setpoint_sb.commands, setpoint_sb.ramp_ticks,
                 settings_used);
        $display("compared %0d results field by field, %0d mismatches",
                 setpoint_sb.compared, setpoint_sb.mismatches);
        if (setpoint_sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
